### hdl/tsac_pkg.sv
`timescale 1ns / 1ps

package tsac_pkg;

  // fixed field widths of the request and response
  localparam int unsigned AddrW   = 16;
  localparam int unsigned TagW    = 8;
  localparam int unsigned SetOutW = 6;
  localparam int unsigned CntW    = 16;

  // widths that hold the largest set count and line size
  localparam int unsigned SetKW  = 11;
  localparam int unsigned LineKW = 7;

  // fixed-point reciprocals are scaled by two to this power
  localparam int unsigned RecipShift = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [TagW-1:0]  tag_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam cnt_t CntMax = '1;

  // per-set replacement and valid state, cleared after reset
  typedef struct packed {
    logic lru;
    logic valid1;
    logic valid0;
  } set_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP
  } fsm_e;

endpackage

### hdl/tsac_req_if.sv
`timescale 1ns / 1ps

interface tsac_req_if import tsac_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

### hdl/tsac_rsp_if.sv
`timescale 1ns / 1ps

interface tsac_rsp_if import tsac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               way_used;
  logic [SetOutW-1:0] set_index;
  tag_t               tag_value;
  addr_t              fill_line_address;
  cnt_t               hits_way0;
  cnt_t               hits_way1;
  cnt_t               misses_way0;
  cnt_t               misses_way1;

  modport source (
    output valid, output hit, output way_used, output set_index, output tag_value,
    output fill_line_address, output hits_way0, output hits_way1,
    output misses_way0, output misses_way1, input ready
  );
  modport sink (
    input valid, input hit, input way_used, input set_index, input tag_value,
    input fill_line_address, input hits_way0, input hits_way1,
    input misses_way0, input misses_way1, output ready
  );
endinterface

### hdl/tsac_addr_split.sv
`timescale 1ns / 1ps

module tsac_addr_split import tsac_pkg::*; #(
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned LINE_BYTES = 4,
  localparam int unsigned SetW = $clog2(SET_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  addr_t           addr_i,
  output logic            out_valid_o,
  output logic [SetW-1:0] set_o,
  output tag_t            tag_o,
  output addr_t           fill_o
);

  localparam int unsigned TagDiv = LINE_BYTES * SET_COUNT;
  localparam longint unsigned RecipOne = 64'd1 << RecipShift;
  localparam longint unsigned RecipLineL =
    (LINE_BYTES > 1) ? (RecipOne + LINE_BYTES - 1) / LINE_BYTES : 64'd0;
  localparam longint unsigned RecipTagL = (RecipOne + TagDiv - 1) / TagDiv;
  localparam logic [RecipShift-1:0] RecipLine = RecipLineL[RecipShift-1:0];
  localparam logic [RecipShift-1:0] RecipTag  = RecipTagL[RecipShift-1:0];
  localparam logic [SetKW-1:0]  SetK  = SetKW'(SET_COUNT);
  localparam logic [LineKW-1:0] LineK = LineKW'(LINE_BYTES);

  localparam int unsigned ProdW = AddrW + RecipShift;
  localparam int unsigned BaseW = AddrW + SetKW;
  localparam int unsigned FillW = AddrW + LineKW;

  logic [ProdW-1:0] line_prod;
  logic [ProdW-1:0] tag_prod;
  addr_t            line_quo;
  addr_t            line_quo_q;
  addr_t            tag_quo_q;
  logic             s1_vld_q;
  logic             s2_vld_q;
  logic [BaseW-1:0] tag_base;
  logic [BaseW-1:0] set_diff;
  logic [FillW-1:0] fill_full;
  logic [SetW-1:0]  set_q;
  tag_t             tag_q;
  addr_t            fill_q;

  // stage one: quotients by the line size and by the way size via reciprocals
  assign line_prod = {{RecipShift{1'b0}}, addr_i} * {{AddrW{1'b0}}, RecipLine};
  assign tag_prod  = {{RecipShift{1'b0}}, addr_i} * {{AddrW{1'b0}}, RecipTag};
  assign line_quo  = (LINE_BYTES > 1) ? line_prod[ProdW-1:RecipShift] : addr_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      line_quo_q <= line_quo;
      tag_quo_q  <= tag_prod[ProdW-1:RecipShift];
    end
  end

  // stage two: set is the line number less whole ways, fill is the line start
  assign tag_base  = {{SetKW{1'b0}}, tag_quo_q} * {{AddrW{1'b0}}, SetK};
  assign set_diff  = {{SetKW{1'b0}}, line_quo_q} - tag_base;
  assign fill_full = {{LineKW{1'b0}}, line_quo_q} * {{AddrW{1'b0}}, LineK};

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      set_q  <= set_diff[SetW-1:0];
      tag_q  <= tag_quo_q[TagW-1:0];
      fill_q <= fill_full[AddrW-1:0];
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign out_valid_o = s2_vld_q;
  assign set_o       = set_q;
  assign tag_o       = tag_q;
  assign fill_o      = fill_q;

endmodule

### hdl/tsac_set_store.sv
`timescale 1ns / 1ps

module tsac_set_store import tsac_pkg::*; #(
  parameter int unsigned SET_COUNT = 64,
  localparam int unsigned SetW = $clog2(SET_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            busy_o,
  input  logic            rd_en_i,
  input  logic [SetW-1:0] rd_set_i,
  output tag_t            rd_tag0_o,
  output tag_t            rd_tag1_o,
  output set_state_t      rd_state_o,
  input  logic            wr_en_i,
  input  logic [SetW-1:0] wr_set_i,
  input  tag_t            wr_tag0_i,
  input  tag_t            wr_tag1_i,
  input  set_state_t      wr_state_i
);

  logic [2*TagW-1:0] tag_mem [SET_COUNT];
  set_state_t        state_mem [SET_COUNT];

  logic              clr_busy_q;
  logic [SetW-1:0]   clr_idx_q;
  logic              clr_last;
  logic              st_we;
  logic [SetW-1:0]   st_addr;
  set_state_t        st_data;
  logic [2*TagW-1:0] rd_tags_q;
  set_state_t        rd_state_q;

  // clearing pass over the state memory after reset
  assign clr_last = (clr_idx_q == SetW'(SET_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q  <= clr_idx_q + 1'b1;
      clr_busy_q <= !clr_last;
    end
  end

  // state write port shared by the clearing pass and the lookup
  assign st_we   = clr_busy_q || wr_en_i;
  assign st_addr = clr_busy_q ? clr_idx_q : wr_set_i;
  assign st_data = clr_busy_q ? set_state_t'('0) : wr_state_i;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem[st_addr] <= st_data;
    end
  end

  // tag memory, one word holds both ways
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_set_i] <= {wr_tag1_i, wr_tag0_i};
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_tags_q  <= tag_mem[rd_set_i];
      rd_state_q <= state_mem[rd_set_i];
    end
  end

  assign busy_o     = clr_busy_q;
  assign rd_tag0_o  = rd_tags_q[TagW-1:0];
  assign rd_tag1_o  = rd_tags_q[2*TagW-1:TagW];
  assign rd_state_o = rd_state_q;

endmodule

### hdl/two_way_set_assoc_cache_lookup.sv
`timescale 1ns / 1ps
// a request passes the decode pipeline and the set store read before its lookup
//   loads the response register; no new request is taken until the lookup's
//   read-modify-write of the set store is done; a stalled response holds the next lookup
// reset: counters and handshakes clear at once; a clearing pass then walks the
//   set state memory, and no request is taken while it runs

module two_way_set_assoc_cache_lookup import tsac_pkg::*; #(
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned LINE_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsac_req_if.sink    req_i,
  tsac_rsp_if.source  rsp_o
);

  localparam int unsigned SetW = $clog2(SET_COUNT);

  fsm_e            state_q;
  fsm_e            state_d;
  logic            req_ready;
  logic            accept;
  logic            rd_en;
  logic            done;
  logic            store_busy;

  logic            split_vld;
  logic [SetW-1:0] split_set;
  tag_t            split_tag;
  addr_t           split_fill;

  tag_t            rd_tag0;
  tag_t            rd_tag1;
  set_state_t      rd_state;
  tag_t            wr_tag0;
  tag_t            wr_tag1;
  set_state_t      wr_state;

  logic            hit0;
  logic            hit1;
  logic            lk_hit;
  logic            lk_way;

  cnt_t            hit0_cnt_q;
  cnt_t            hit1_cnt_q;
  cnt_t            miss0_cnt_q;
  cnt_t            miss1_cnt_q;

  logic            rsp_vld_q;
  logic            rsp_vld_d;
  logic            rsp_hit_q;
  logic            rsp_way_q;
  logic [SetOutW-1:0] rsp_set_q;
  tag_t            rsp_tag_q;
  addr_t           rsp_fill_q;
  logic [AddrW-1:0] set_ext;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // address decode pipeline
  tsac_addr_split #(
    .SET_COUNT  (SET_COUNT),
    .LINE_BYTES (LINE_BYTES)
  ) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .addr_i      (req_i.address),
    .out_valid_o (split_vld),
    .set_o       (split_set),
    .tag_o       (split_tag),
    .fill_o      (split_fill)
  );

  // tag and set state memories
  tsac_set_store #(
    .SET_COUNT (SET_COUNT)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (store_busy),
    .rd_en_i    (rd_en),
    .rd_set_i   (split_set),
    .rd_tag0_o  (rd_tag0),
    .rd_tag1_o  (rd_tag1),
    .rd_state_o (rd_state),
    .wr_en_i    (done),
    .wr_set_i   (split_set),
    .wr_tag0_i  (wr_tag0),
    .wr_tag1_i  (wr_tag1),
    .wr_state_i (wr_state)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, request ready, memory read and write-back strobes
  always_comb begin
    state_d   = state_q;
    req_ready = 1'b0;
    rd_en     = 1'b0;
    done      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready = !store_busy;
        if (req_i.valid && !store_busy) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (split_vld) begin
          rd_en   = 1'b1;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready = req_ready;
  assign accept      = req_i.valid && req_ready;

  // tag compare, way zero first, victim from the lru bit
  assign hit0   = rd_state.valid0 && (rd_tag0 == split_tag);
  assign hit1   = rd_state.valid1 && (rd_tag1 == split_tag);
  assign lk_hit = hit0 || hit1;
  assign lk_way = hit0 ? 1'b0 : (hit1 ? 1'b1 : rd_state.lru);

  // write-back: refill the victim on a miss, the other way becomes lru
  assign wr_tag0         = (!lk_hit && !lk_way) ? split_tag : rd_tag0;
  assign wr_tag1         = (!lk_hit && lk_way) ? split_tag : rd_tag1;
  assign wr_state.valid0 = rd_state.valid0 || (!lk_hit && !lk_way);
  assign wr_state.valid1 = rd_state.valid1 || (!lk_hit && lk_way);
  assign wr_state.lru    = !lk_way;

  // saturating hit and miss counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit0_cnt_q  <= '0;
      hit1_cnt_q  <= '0;
      miss0_cnt_q <= '0;
      miss1_cnt_q <= '0;
    end else if (done) begin
      if (lk_hit && !lk_way) hit0_cnt_q <= sat_inc(hit0_cnt_q);
      if (lk_hit && lk_way) hit1_cnt_q <= sat_inc(hit1_cnt_q);
      if (!lk_hit && !lk_way) miss0_cnt_q <= sat_inc(miss0_cnt_q);
      if (!lk_hit && lk_way) miss1_cnt_q <= sat_inc(miss1_cnt_q);
    end
  end

  // response register
  assign rsp_vld_d = done ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_vld_q);
  assign set_ext   = AddrW'(split_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_hit_q  <= lk_hit;
      rsp_way_q  <= lk_way;
      rsp_set_q  <= set_ext[SetOutW-1:0];
      rsp_tag_q  <= split_tag;
      rsp_fill_q <= lk_hit ? '0 : split_fill;
    end
  end

  assign rsp_o.valid             = rsp_vld_q;
  assign rsp_o.hit               = rsp_hit_q;
  assign rsp_o.way_used          = rsp_way_q;
  assign rsp_o.set_index         = rsp_set_q;
  assign rsp_o.tag_value         = rsp_tag_q;
  assign rsp_o.fill_line_address = rsp_fill_q;
  assign rsp_o.hits_way0         = hit0_cnt_q;
  assign rsp_o.hits_way1         = hit1_cnt_q;
  assign rsp_o.misses_way0       = miss0_cnt_q;
  assign rsp_o.misses_way1       = miss1_cnt_q;

  // both ways never hold the same valid tag
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> !(hit0 && hit1))
    else $error("both ways hit in one set");

  // the lookup never writes the store during the clearing pass
  a_no_wr_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !done)
    else $error("set store written while clearing");

  // a hit in way zero bumps its counter unless saturated
  a_hit0_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && lk_hit && !lk_way && (hit0_cnt_q != CntMax))
      |=> (hit0_cnt_q == $past(hit0_cnt_q) + 16'd1))
    else $error("way zero hit counter did not advance");

  // a finished lookup always presents its response next cycle
  a_rsp_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (rsp_vld_q && (state_q == ST_IDLE)))
    else $error("lookup finished without a response");

endmodule
